FILE: hdl/ddodo_pkg.sv
`default_nettype none
package ddodo_pkg;

    localparam int ANGLE_ITERATIONS_DEF = 24;
    localparam int POS_ACC_WIDTH_DEF    = 48;

    localparam logic CFG_CM_PER_TICK   = 1'b0;
    localparam logic CFG_WHEEL_BASE_CM = 1'b1;

    localparam logic signed [31:0] CM_PER_TICK_RST   = -32'sd36329;
    localparam logic        [30:0] WHEEL_BASE_CM_RST = 31'd2909798;

    localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] SAT_POS     = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SAT_NEG     = -32'sh7FFFFFFF;

    function automatic logic signed [35:0] atan_q30(input logic [4:0] idx);
        logic signed [35:0] v;
        case (idx)
            5'd0:  v = 36'sh03243F6A8;
            5'd1:  v = 36'sh01DAC6705;
            5'd2:  v = 36'sh00FADBAFC;
            5'd3:  v = 36'sh007F56EA6;
            5'd4:  v = 36'sh003FEAB76;
            5'd5:  v = 36'sh001FFD55B;
            5'd6:  v = 36'sh000FFFAAA;
            5'd7:  v = 36'sh0007FFF55;
            5'd8:  v = 36'sh0003FFFEA;
            5'd9:  v = 36'sh0001FFFFD;
            5'd10: v = 36'sh0000FFFFF;
            5'd11: v = 36'sh00007FFFF;
            5'd12: v = 36'sh00003FFFF;
            5'd13: v = 36'sh00001FFFF;
            5'd14: v = 36'sh00000FFFF;
            5'd15: v = 36'sh000007FFF;
            5'd16: v = 36'sh000003FFF;
            5'd17: v = 36'sh000001FFF;
            5'd18: v = 36'sh000000FFF;
            5'd19: v = 36'sh0000007FF;
            5'd20: v = 36'sh0000003FF;
            5'd21: v = 36'sh0000001FF;
            5'd22: v = 36'sh0000000FF;
            5'd23: v = 36'sh00000007F;
            5'd24: v = 36'sh00000003F;
            5'd25: v = 36'sh00000001F;
            5'd26: v = 36'sh00000000F;
            5'd27: v = 36'sh000000008;
            5'd28: v = 36'sh000000004;
            5'd29: v = 36'sh000000002;
            5'd30: v = 36'sh000000001;
            default: v = 36'sh000000000;
        endcase
        return v;
    endfunction

    // symmetric saturation of a quotient magnitude
    function automatic logic signed [31:0] quot_sat(input logic [63:0] q, input logic neg);
        logic signed [31:0] m;
        m = (q > 64'd2147483647) ? SAT_POS : $signed({1'b0, q[30:0]});
        return neg ? -m : m;
    endfunction

    // two's complement saturation of a signed quotient
    function automatic logic signed [31:0] trunc_sat(input logic [63:0] q, input logic neg);
        logic signed [32:0] n;
        n = -$signed({1'b0, q[31:0]});
        if (neg)
            return (q >= 64'h80000000) ? 32'sh80000000 : n[31:0];
        return (q > 64'd2147483647) ? SAT_POS : $signed(q[31:0]);
    endfunction

endpackage
`default_nettype wire

FILE: hdl/diff_drive_wheel_odometry.sv
// Differential-drive wheel odometry.
// Input channel (i_in_valid / o_in_ready) takes absolute left/right encoder
// counts and a microsecond stamp. Output channel (o_out_valid / i_out_ready)
// gives position, yaw, velocities and a freshness flag. Config channel
// (i_cfg_valid / o_cfg_ready, always ready) writes cm_per_tick (index 0) and
// wheel_base_cm (index 1); write only while the block is idle.
// The first sample after reset only stores the counts and gives no result.
// Every later sample runs through one sequencer that shares a 34x34
// multiplier, a 64-bit restoring divider (one quotient bit per cycle) and a
// CORDIC rotator (one iteration per cycle). The /100 of the position readout
// is a reciprocal multiply with a few compare-subtract fixups.
// Most of the time per sample is spent in the three divider passes; fewer
// passes run when dt is zero or the heading step needs no division.
// o_in_ready is high only while the sequencer is idle.
// The result sits in an output register; the next sample may be taken while
// it waits. If the receiver stalls, a finished next result waits in the
// sequencer until the output register frees up.
// Reset (synchronous, active low) restores the register defaults and clears
// pose, velocities and the first-sample flag.
`default_nettype none
module diff_drive_wheel_odometry
    import ddodo_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF,
    parameter int POS_ACC_WIDTH    = POS_ACC_WIDTH_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire        [31:0] i_left_count,
    input  wire        [31:0] i_right_count,
    input  wire        [31:0] i_stamp_us,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic       [31:0] o_pos_x_m,
    output logic       [31:0] o_pos_y_m,
    output logic       [30:0] o_yaw_rad,
    output logic       [31:0] o_lin_vel,
    output logic       [31:0] o_ang_vel,
    output logic              o_vel_fresh,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire               i_cfg_index,
    input  wire        [31:0] i_cfg_data
);

    localparam int CW = $clog2(ANGLE_ITERATIONS);
    localparam int W  = POS_ACC_WIDTH;
    localparam logic signed [65:0] ACC_HI = (66'sd1 <<< (W - 1)) - 66'sd1;
    localparam logic signed [65:0] ACC_LO = -ACC_HI - 66'sd1;
    // magnitudes at or above 100 * 2^31 saturate after /100
    localparam logic [63:0] DIV100_SAT = 64'd214748364800;
    // floor(2^38 / 100)
    localparam logic [31:0] RECIP_100  = 32'd2748779069;

    typedef enum logic [5:0] {
        S_IDLE, S_MUL_L, S_MUL_R, S_DIFF, S_STEP_CHK, S_STEP_DONE, S_HEAD, S_WRAP,
        S_CORD_INIT, S_CORD, S_CORD_DONE, S_MX0, S_MX1, S_MX2, S_MY0, S_MY1, S_MY2,
        S_VEL, S_LM0, S_LM1, S_LDIV, S_LIN_DONE, S_AM0, S_ADIV, S_ANG_DONE, S_GM0,
        S_GATE, S_XDIV, S_XDONE, S_YDIV, S_YDONE, S_DIV, S_C100_MUL, S_C100_BACK,
        S_C100_FIX
    } t_state;

    t_state r_state, r_dret;

    logic signed [31:0] r_cm;
    logic        [30:0] r_wb;
    logic               r_seen;
    logic        [31:0] r_prev_l, r_prev_r, r_prev_st;
    logic signed [33:0] r_head;
    logic signed [W-1:0] r_acc_x, r_acc_y;
    logic signed [31:0] r_kept_lin, r_kept_ang;

    logic signed [31:0] r_dlt_l, r_dlt_r;
    logic        [31:0] r_dt;
    logic signed [55:0] r_dl, r_dr, r_mean;
    logic signed [56:0] r_diff;
    logic signed [31:0] r_step, r_lin, r_ang, r_ox;
    logic signed [35:0] r_z;
    logic signed [33:0] r_x, r_y;
    logic               r_flip, r_fresh;
    logic [CW-1:0]      r_ccnt;
    logic signed [89:0] r_pacc;
    logic        [63:0] r_dnum, r_den;
    logic        [64:0] r_rem;
    logic        [5:0]  r_dcnt;
    logic               r_dneg;

    logic               r_o_valid;
    logic        [31:0] r_o_x, r_o_y, r_o_lin, r_o_ang;
    logic        [30:0] r_o_yaw;
    logic               r_o_fresh;

    // shared multiplier
    logic signed [33:0] m_a, m_b;
    logic signed [67:0] m_p;
    logic signed [27:0] mean_hi;
    logic        [55:0] mean_mag;
    logic        [56:0] diff_mag;
    logic        [30:0] step_mag;
    logic signed [32:0] dv;
    logic        [32:0] dv_mag;
    logic               out_load;

    assign mean_hi  = r_mean[55:28];
    assign mean_mag = r_mean[55] ? 56'(-r_mean) : 56'(r_mean);
    assign diff_mag = r_diff[56] ? 57'(-r_diff) : 57'(r_diff);
    assign step_mag = r_step[31] ? 31'(-r_step) : 31'(r_step);
    assign dv       = 33'(r_lin) - 33'(r_kept_lin);
    assign dv_mag   = dv[32] ? 33'(-dv) : 33'(dv);
    assign out_load = (r_state == S_YDONE) && (!r_o_valid || i_out_ready);

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_MUL_L: begin
                m_a = 34'(r_cm);
                m_b = 34'(r_dlt_l);
            end
            S_MUL_R: begin
                m_a = 34'(r_cm);
                m_b = 34'(r_dlt_r);
            end
            S_MX0: begin
                m_a = $signed({6'b0, r_mean[27:0]});
                m_b = r_x;
            end
            S_MX1: begin
                m_a = 34'(mean_hi);
                m_b = r_x;
            end
            S_MY0: begin
                m_a = $signed({6'b0, r_mean[27:0]});
                m_b = r_y;
            end
            S_MY1: begin
                m_a = 34'(mean_hi);
                m_b = r_y;
            end
            S_LM0: begin
                m_a = $signed({2'b0, mean_mag[31:0]});
                m_b = 34'sd10000;
            end
            S_LM1: begin
                m_a = $signed({17'b0, mean_mag[48:32]});
                m_b = 34'sd10000;
            end
            S_AM0: begin
                m_a = $signed({3'b0, step_mag});
                m_b = 34'sd1000000;
            end
            S_GM0: begin
                m_a = $signed({1'b0, dv_mag});
                m_b = 34'sd125;
            end
            S_C100_MUL: begin
                m_a = $signed({2'b0, r_dnum[37:6]});
                m_b = $signed({2'b0, RECIP_100});
            end
            S_C100_BACK: begin
                m_a = $signed({2'b0, r_dnum[31:0]});
                m_b = 34'sd100;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign m_p = m_a * m_b;

    // position update with saturation at the accumulator width
    logic signed [57:0] pterm;
    logic signed [65:0] sum_x, sum_y, sat_x, sat_y;
    assign pterm = 58'(r_pacc >>> 30);
    assign sum_x = 66'(r_acc_x) + 66'(pterm);
    assign sum_y = 66'(r_acc_y) - 66'(pterm);
    assign sat_x = (sum_x > ACC_HI) ? ACC_HI : ((sum_x < ACC_LO) ? ACC_LO : sum_x);
    assign sat_y = (sum_y > ACC_HI) ? ACC_HI : ((sum_y < ACC_LO) ? ACC_LO : sum_y);

    logic [64:0] acc_x_mag, acc_y_mag;
    assign acc_x_mag = r_acc_x[W-1] ? 65'(-66'(r_acc_x)) : 65'(66'(r_acc_x));
    assign acc_y_mag = r_acc_y[W-1] ? 65'(-66'(r_acc_y)) : 65'(66'(r_acc_y));

    // CORDIC step
    logic signed [33:0] cx_sh, cy_sh;
    logic signed [35:0] z_init;
    logic signed [35:0] atan_v;
    assign cx_sh  = r_x >>> r_ccnt;
    assign cy_sh  = r_y >>> r_ccnt;
    assign z_init = 36'(r_head) <<< 2;
    assign atan_v = atan_q30(5'(r_ccnt));

    // divider step
    logic [64:0] d_try;
    logic        d_ge;
    assign d_try = {r_rem[63:0], r_dnum[63]};
    assign d_ge  = d_try >= {1'b0, r_den};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_o_valid;
    assign o_pos_x_m   = r_o_x;
    assign o_pos_y_m   = r_o_y;
    assign o_yaw_rad   = r_o_yaw;
    assign o_lin_vel   = r_o_lin;
    assign o_ang_vel   = r_o_ang;
    assign o_vel_fresh = r_o_fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_dret     <= S_IDLE;
            r_cm       <= CM_PER_TICK_RST;
            r_wb       <= WHEEL_BASE_CM_RST;
            r_seen     <= 1'b0;
            r_prev_st  <= '0;
            r_head     <= '0;
            r_acc_x    <= '0;
            r_acc_y    <= '0;
            r_kept_lin <= '0;
            r_kept_ang <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CM_PER_TICK:   r_cm <= $signed(i_cfg_data);
                    CFG_WHEEL_BASE_CM: r_wb <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (out_load)
                r_o_valid <= 1'b1;
            else if (r_o_valid && i_out_ready)
                r_o_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_prev_l <= i_left_count;
                        r_prev_r <= i_right_count;
                        if (!r_seen) begin
                            r_seen <= 1'b1;
                        end else begin
                            r_dlt_l   <= $signed(i_left_count - r_prev_l);
                            r_dlt_r   <= $signed(i_right_count - r_prev_r);
                            r_dt      <= i_stamp_us - r_prev_st;
                            r_prev_st <= i_stamp_us;
                            r_state   <= S_MUL_L;
                        end
                    end
                end
                S_MUL_L: begin
                    r_dl    <= 56'(m_p >>> 8);
                    r_state <= S_MUL_R;
                end
                S_MUL_R: begin
                    r_dr    <= 56'(m_p >>> 8);
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_mean  <= 56'((57'(r_dl) + 57'(r_dr)) >>> 1);
                    r_diff  <= 57'(r_dr) - 57'(r_dl);
                    r_state <= S_STEP_CHK;
                end
                S_STEP_CHK: begin
                    if (r_wb == '0 || r_diff == '0) begin
                        r_step  <= '0;
                        r_state <= S_HEAD;
                    end else if (diff_mag >= 57'({r_wb, 3'b000})) begin
                        r_step  <= r_diff[56] ? SAT_NEG : SAT_POS;
                        r_state <= S_HEAD;
                    end else begin
                        r_dnum  <= 64'(diff_mag) << 28;
                        r_den   <= 64'(r_wb);
                        r_dneg  <= r_diff[56];
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_dret  <= S_STEP_DONE;
                        r_state <= S_DIV;
                    end
                end
                S_STEP_DONE: begin
                    r_step  <= quot_sat(r_dnum, r_dneg);
                    r_state <= S_HEAD;
                end
                S_HEAD: begin
                    r_head  <= r_head + 34'(r_step);
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    if (r_head > PI_Q28)
                        r_head <= r_head - TWO_PI_Q28;
                    else if (r_head < -PI_Q28)
                        r_head <= r_head + TWO_PI_Q28;
                    else
                        r_state <= S_CORD_INIT;
                end
                S_CORD_INIT: begin
                    // fold into +-pi/2, flip the result back afterwards
                    if (z_init > HALF_PI_Q30) begin
                        r_z    <= z_init - PI_Q30;
                        r_flip <= 1'b1;
                    end else if (z_init < -HALF_PI_Q30) begin
                        r_z    <= z_init + PI_Q30;
                        r_flip <= 1'b1;
                    end else begin
                        r_z    <= z_init;
                        r_flip <= 1'b0;
                    end
                    r_x     <= CORDIC_GAIN;
                    r_y     <= '0;
                    r_ccnt  <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - cy_sh;
                        r_y <= r_y + cx_sh;
                        r_z <= r_z - atan_v;
                    end else begin
                        r_x <= r_x + cy_sh;
                        r_y <= r_y - cx_sh;
                        r_z <= r_z + atan_v;
                    end
                    r_ccnt <= r_ccnt + 1'b1;
                    if (r_ccnt == CW'(ANGLE_ITERATIONS - 1))
                        r_state <= S_CORD_DONE;
                end
                S_CORD_DONE: begin
                    if (r_flip) begin
                        r_x <= -r_x;
                        r_y <= -r_y;
                    end
                    r_state <= S_MX0;
                end
                S_MX0: begin
                    r_pacc  <= 90'(m_p);
                    r_state <= S_MX1;
                end
                S_MX1: begin
                    r_pacc  <= r_pacc + (90'(m_p) <<< 28);
                    r_state <= S_MX2;
                end
                S_MX2: begin
                    r_acc_x <= W'(sat_x);
                    r_state <= S_MY0;
                end
                S_MY0: begin
                    r_pacc  <= 90'(m_p);
                    r_state <= S_MY1;
                end
                S_MY1: begin
                    r_pacc  <= r_pacc + (90'(m_p) <<< 28);
                    r_state <= S_MY2;
                end
                S_MY2: begin
                    r_acc_y <= W'(sat_y);
                    r_state <= S_VEL;
                end
                S_VEL: begin
                    if (r_dt == '0) begin
                        r_fresh <= 1'b0;
                        r_state <= S_XDIV;
                    end else if (mean_mag >= (56'd1 << 49)) begin
                        r_lin   <= r_mean[55] ? SAT_NEG : SAT_POS;
                        r_state <= S_AM0;
                    end else begin
                        r_state <= S_LM0;
                    end
                end
                S_LM0: begin
                    r_pacc  <= 90'(m_p);
                    r_state <= S_LM1;
                end
                S_LM1: begin
                    r_pacc  <= r_pacc + (90'(m_p) <<< 32);
                    r_state <= S_LDIV;
                end
                S_LDIV: begin
                    r_dnum  <= r_pacc[63:0];
                    r_den   <= 64'(r_dt);
                    r_dneg  <= r_mean[55];
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_dret  <= S_LIN_DONE;
                    r_state <= S_DIV;
                end
                S_LIN_DONE: begin
                    r_lin   <= quot_sat(r_dnum, r_dneg);
                    r_state <= S_AM0;
                end
                S_AM0: begin
                    r_pacc  <= 90'(m_p);
                    r_state <= S_ADIV;
                end
                S_ADIV: begin
                    r_dnum  <= r_pacc[63:0];
                    r_den   <= 64'({r_dt, 12'b0});
                    r_dneg  <= r_step[31];
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_dret  <= S_ANG_DONE;
                    r_state <= S_DIV;
                end
                S_ANG_DONE: begin
                    r_ang   <= quot_sat(r_dnum, r_dneg);
                    r_state <= S_GM0;
                end
                S_GM0: begin
                    r_pacc  <= 90'(m_p);
                    r_state <= S_GATE;
                end
                S_GATE: begin
                    // acceleration gate
                    if (r_pacc < $signed({46'b0, r_dt, 12'b0})) begin
                        r_kept_lin <= r_lin;
                        r_kept_ang <= r_ang;
                        r_fresh    <= 1'b1;
                    end else begin
                        r_fresh    <= 1'b0;
                    end
                    r_state <= S_XDIV;
                end
                S_XDIV: begin
                    r_dnum  <= acc_x_mag[63:0];
                    r_dneg  <= r_acc_x[W-1];
                    r_dret  <= S_XDONE;
                    r_state <= S_C100_MUL;
                end
                S_XDONE: begin
                    r_ox    <= trunc_sat(r_dnum, r_dneg);
                    r_state <= S_YDIV;
                end
                S_YDIV: begin
                    r_dnum  <= acc_y_mag[63:0];
                    r_dneg  <= r_acc_y[W-1];
                    r_dret  <= S_YDONE;
                    r_state <= S_C100_MUL;
                end
                S_YDONE: begin
                    // hold until the output register is free
                    if (out_load) begin
                        r_o_x     <= r_ox;
                        r_o_y     <= trunc_sat(r_dnum, r_dneg);
                        r_o_yaw   <= 31'(-r_head);
                        r_o_lin   <= r_kept_lin;
                        r_o_ang   <= 32'(-r_kept_ang);
                        r_o_fresh <= r_fresh;
                        r_state   <= S_IDLE;
                    end
                end
                S_DIV: begin
                    r_rem  <= d_ge ? (d_try - {1'b0, r_den}) : d_try;
                    r_dnum <= {r_dnum[62:0], d_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 6'd63)
                        r_state <= r_dret;
                end
                S_C100_MUL: begin
                    // estimate from the top 32 bits, never above the true quotient
                    if (r_dnum >= DIV100_SAT) begin
                        r_dnum  <= '1;
                        r_state <= r_dret;
                    end else begin
                        r_rem   <= {1'b0, r_dnum};
                        r_dnum  <= {32'b0, m_p[63:32]};
                        r_state <= S_C100_BACK;
                    end
                end
                S_C100_BACK: begin
                    r_rem   <= r_rem - {1'b0, m_p[63:0]};
                    r_state <= S_C100_FIX;
                end
                S_C100_FIX: begin
                    // estimate is short by at most three
                    if (r_rem >= 65'd100) begin
                        r_rem  <= r_rem - 65'd100;
                        r_dnum <= r_dnum + 64'd1;
                    end else begin
                        r_state <= r_dret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hdl/ddodo_chk.sv
`default_nettype none
module ddodo_chk
    import ddodo_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_ready,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire [31:0] o_pos_x_m,
    input wire [30:0] o_yaw_rad,
    input wire [31:0] o_ang_vel,
    input wire        o_vel_fresh,
    input wire        o_cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pos_x_m)
            && $stable(o_yaw_rad))
        else $error("stalled result changed");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("result or busy after reset");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $signed(o_yaw_rad) >= -31'sd843314857
            && $signed(o_yaw_rad) <= 31'sd843314857)
        else $error("yaw outside +-pi");

    a_ang_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_ang_vel != 32'h80000000)
        else $error("angular velocity saturated asymmetrically");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind diff_drive_wheel_odometry ddodo_chk u_ddodo_chk (.*);
`default_nettype wire

FILE: tb/diff_drive_wheel_odometry_tb.sv
`timescale 1ns / 100ps
module diff_drive_wheel_odometry_tb;
    import ddodo_pkg::*;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  DRAIN_CYCLES   = 400;
    localparam int  ACC_WIDTH      = POS_ACC_WIDTH_DEF;
    localparam int  CORDIC_STEPS   = ANGLE_ITERATIONS_DEF;
    localparam longint SAT31       = 64'sd2147483647;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [30:0] yaw;
        logic [31:0] lin_vel;
        logic [31:0] ang_vel;
        logic        fresh;
    } pose_t;

    class pose_tracker;
        pose_t           pending_poses[$];
        int              errors;
        longint          tick_scale;
        longint          base_cm;
        bit              have_first;
        logic [31:0]     last_left, last_right, last_stamp;
        longint          heading, acc_x, acc_y, lin_kept, ang_kept;

        function new();
            errors = 0;
            tick_scale = CM_PER_TICK_RST;
            base_cm = WHEEL_BASE_CM_RST;
            have_first = 0;
            last_left = '0;
            last_right = '0;
            last_stamp = '0;
            heading = 0;
            acc_x = 0;
            acc_y = 0;
            lin_kept = 0;
            ang_kept = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] data);
            if (idx == CFG_CM_PER_TICK)
                tick_scale = longint'($signed(data));
            else
                base_cm = longint'(data[30:0]);
        endfunction

        // floor(a * c / 2^30) without 64-bit overflow
        function longint scale_q30(longint a, longint c);
            longint hi, lo;
            hi = a >>> 30;
            lo = a - hi * 64'sd1073741824;
            return hi * c + ((lo * c) >>> 30);
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        function longint div_sat(longint unsigned num, bit neg, longint unsigned den);
            longint unsigned q;
            longint r;
            q = num / den;
            r = (q > 64'd2147483647) ? SAT31 : longint'(q);
            return neg ? -r : r;
        endfunction

        function void note_sample(logic [31:0] lc, logic [31:0] rc, logic [31:0] st);
            longint dl, dr, mean, diff, step, x, y, z, t, lin, ang, dv, acc_hi;
            longint unsigned mag, dt;
            logic [31:0] dtick;
            bit flip, fresh;
            pose_t p;
            if (!have_first) begin
                last_left = lc;
                last_right = rc;
                have_first = 1;
                return;
            end
            dtick = lc - last_left;
            dl = (tick_scale * longint'($signed(dtick))) >>> 8;
            dtick = rc - last_right;
            dr = (tick_scale * longint'($signed(dtick))) >>> 8;
            last_left = lc;
            last_right = rc;
            dtick = st - last_stamp;
            dt = longint'(dtick);
            last_stamp = st;

            mean = (dl + dr) >>> 1;
            diff = dr - dl;
            mag = (diff < 0) ? longint'(-diff) : longint'(diff);
            if (base_cm == 0 || diff == 0)
                step = 0;
            else if (mag >= 8 * base_cm)
                step = (diff < 0) ? -SAT31 : SAT31;
            else
                step = div_sat(mag << 28, diff < 0, base_cm);

            heading += step;
            while (heading > longint'(PI_Q28))
                heading -= longint'(TWO_PI_Q28);
            while (heading < -longint'(PI_Q28))
                heading += longint'(TWO_PI_Q28);

            // rotation-mode CORDIC after folding into +-pi/2
            z = heading * 4;
            x = 64'sh26DD3B6A;
            y = 0;
            flip = 0;
            if (z > longint'(HALF_PI_Q30)) begin
                z -= longint'(PI_Q30);
                flip = 1;
            end else if (z < -longint'(HALF_PI_Q30)) begin
                z += longint'(PI_Q30);
                flip = 1;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    x = t;
                    z -= longint'(atan_q30(5'(i)));
                end else begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    x = t;
                    z += longint'(atan_q30(5'(i)));
                end
            end
            if (flip) begin
                x = -x;
                y = -y;
            end

            acc_hi = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
            acc_x = clamp(acc_x + scale_q30(mean, x), -acc_hi - 1, acc_hi);
            acc_y = clamp(acc_y - scale_q30(mean, y), -acc_hi - 1, acc_hi);

            fresh = 0;
            if (dt != 0) begin
                mag = (mean < 0) ? longint'(-mean) : longint'(mean);
                if (mag >= (64'd1 << 49))
                    lin = (mean < 0) ? -SAT31 : SAT31;
                else
                    lin = div_sat(mag * 10000, mean < 0, dt);
                mag = (step < 0) ? longint'(-step) : longint'(step);
                ang = div_sat(mag * 1000000, step < 0, dt * 4096);
                dv = lin - lin_kept;
                mag = (dv < 0) ? longint'(-dv) : longint'(dv);
                // acceleration gate
                if (mag * 125 < dt * 4096) begin
                    lin_kept = lin;
                    ang_kept = ang;
                    fresh = 1;
                end
            end

            p.pos_x = 32'(clamp(acc_x / 100, -SAT31 - 1, SAT31));
            p.pos_y = 32'(clamp(acc_y / 100, -SAT31 - 1, SAT31));
            p.yaw = 31'(-heading);
            p.lin_vel = 32'(lin_kept);
            p.ang_vel = 32'(-ang_kept);
            p.fresh = fresh;
            pending_poses.push_back(p);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        task check_pose(pose_t got);
            pose_t want;
            if (pending_poses.size() == 0) begin
                report("unexpected transaction", got.pos_x, 32'h0);
                return;
            end
            want = pending_poses.pop_front();
            if (got.pos_x !== want.pos_x)
                report("pos_x_m", got.pos_x, want.pos_x);
            if (got.pos_y !== want.pos_y)
                report("pos_y_m", got.pos_y, want.pos_y);
            if (got.yaw !== want.yaw)
                report("yaw_rad", {1'b0, got.yaw}, {1'b0, want.yaw});
            if (got.lin_vel !== want.lin_vel)
                report("lin_vel", got.lin_vel, want.lin_vel);
            if (got.ang_vel !== want.ang_vel)
                report("ang_vel", got.ang_vel, want.ang_vel);
            if (got.fresh !== want.fresh)
                report("vel_fresh", {31'b0, got.fresh}, {31'b0, want.fresh});
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_left_count;
    logic [31:0] i_right_count;
    logic [31:0] i_stamp_us;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_pos_x_m;
    logic [31:0] o_pos_y_m;
    logic [30:0] o_yaw_rad;
    logic [31:0] o_lin_vel;
    logic [31:0] o_ang_vel;
    logic        o_vel_fresh;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    pose_tracker tracker;
    int          stall_cnt;
    bit          in_steady;
    bit          out_steady;
    logic [31:0] cur_left, cur_right, cur_stamp;
    int          spd_left, spd_right;

    diff_drive_wheel_odometry dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_left_count  (i_left_count),
        .i_right_count (i_right_count),
        .i_stamp_us    (i_stamp_us),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pos_x_m     (o_pos_x_m),
        .o_pos_y_m     (o_pos_y_m),
        .o_yaw_rad     (o_yaw_rad),
        .o_lin_vel     (o_lin_vel),
        .o_ang_vel     (o_ang_vel),
        .o_vel_fresh   (o_vel_fresh),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        tracker = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_left_count = '0;
        i_right_count = '0;
        i_stamp_us = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CM_PER_TICK;
        i_cfg_data = '0;
        in_steady = 1'b0;
        out_steady = 1'b0;
    end

    // result side: random stalls, checks at the rising edge
    always @(posedge i_clk) begin
        pose_t got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.pos_x = o_pos_x_m;
            got.pos_y = o_pos_y_m;
            got.yaw = o_yaw_rad;
            got.lin_vel = o_lin_vel;
            got.ang_vel = o_ang_vel;
            got.fresh = o_vel_fresh;
            tracker.check_pose(got);
        end
    end

    initial begin
        int n;
        int cnt;
        cnt = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (cnt % 40 == 0)
                out_steady = ($urandom_range(0, 3) == 0);
            cnt++;
            n = out_steady ? 0 : $urandom_range(0, 3);
            if (n > 0) begin
                i_out_ready = 1'b0;
                repeat (n) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            @(posedge i_clk);
            while (!o_out_valid)
                @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // called at a falling edge, returns at a falling edge
    task send_sample(logic [31:0] lc, logic [31:0] rc, logic [31:0] st);
        int n;
        n = in_steady ? 0 : $urandom_range(0, 3);
        if (n > 0) begin
            i_in_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_left_count = lc;
        i_right_count = rc;
        i_stamp_us = st;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        tracker.note_sample(lc, rc, st);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task wait_idle();
        while (tracker.pending_poses.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task write_reg(logic idx, logic [31:0] data);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        tracker.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // mostly smooth motion, some noise, dropped stamps and jumps
    task drive_random(int count);
        int dt;
        for (int k = 0; k < count; k++) begin
            if (k % 50 == 0)
                in_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                0: begin
                    cur_left = $urandom;
                    cur_right = $urandom;
                    cur_stamp = $urandom;
                end
                1: begin
                    cur_left += $urandom_range(0, 200);
                end
                2: begin
                    cur_left += $urandom_range(0, 1 << 20) - (1 << 19);
                    cur_right += $urandom_range(0, 1 << 20) - (1 << 19);
                    cur_stamp += $urandom_range(1, 500);
                end
                default: begin
                    spd_left = spd_left + $urandom_range(0, 40) - 20;
                    spd_right = spd_right + $urandom_range(0, 40) - 20;
                    if (spd_left > 600 || spd_left < -600)
                        spd_left = 0;
                    if (spd_right > 600 || spd_right < -600)
                        spd_right = spd_right / 2;
                    dt = $urandom_range(1000, 30000);
                    cur_left += spd_left * dt / 1000;
                    cur_right += spd_right * dt / 1000;
                    cur_stamp += dt;
                end
            endcase
            send_sample(cur_left, cur_right, cur_stamp);
        end
        in_steady = 1'b0;
    endtask

    initial begin
        logic [31:0] cpt;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // first sample, then zero dt
        send_sample(32'd0, 32'd0, 32'd0);
        send_sample(32'd0, 32'd0, 32'd0);
        send_sample(32'd100, 32'd100, 32'd10000);
        send_sample(32'd300, 32'd250, 32'd20000);
        send_sample(32'd300, 32'd250, 32'd20000);
        // count wrap across the signed limit
        send_sample(32'h7FFFFFFF, 32'h7FFFFFF0, 32'd30000);
        send_sample(32'h80000010, 32'h80000005, 32'd40000);
        // acceleration gate fails on a sudden jump with short dt
        send_sample(32'h80100000, 32'h80100000, 32'd40010);
        // huge heading step, both signs
        send_sample(32'h00100000, 32'h80100000, 32'd50000);
        send_sample(32'h80100000, 32'h00100000, 32'd60000);
        // stamp wrap
        send_sample(32'h80100000, 32'h00100000, 32'hFFFFFF00);
        send_sample(32'h80100400, 32'h00100300, 32'h00000400);
        send_sample(32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF);
        send_sample(32'h00000000, 32'hFFFFFFFF, 32'h00000000);
        send_sample(32'h55555555, 32'hAAAAAAAA, 32'h55555555);
        send_sample(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
        cur_left = 32'hAAAAAAAA;
        cur_right = 32'h55555555;
        cur_stamp = 32'hAAAAAAAA;
        spd_left = 0;
        spd_right = 0;
        drive_random(230);

        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    // largest travel per tick, narrowest base: saturation
                    write_reg(CFG_CM_PER_TICK, 32'h7FFFFFFF);
                    write_reg(CFG_WHEEL_BASE_CM, 32'd65536);
                end
                1: begin
                    write_reg(CFG_CM_PER_TICK, 32'h80000000);
                    write_reg(CFG_WHEEL_BASE_CM, 32'h7FFFFFFF);
                end
                4: begin
                    write_reg(CFG_CM_PER_TICK, CM_PER_TICK_RST);
                    write_reg(CFG_WHEEL_BASE_CM, {1'b0, WHEEL_BASE_CM_RST});
                end
                default: begin
                    cpt = $urandom_range(0, 1 << 22);
                    if ($urandom_range(0, 1))
                        cpt = -cpt;
                    write_reg(CFG_CM_PER_TICK, cpt);
                    write_reg(CFG_WHEEL_BASE_CM, $urandom_range(65536, 32'h7FFFFFFF));
                end
            endcase
            drive_random((ph < 2) ? 80 : 230);
        end

        wait_idle();
        if (tracker.errors == 0 && tracker.pending_poses.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
